### design/swm_pkg.sv
package swm_pkg;

  // Width of the win_len register and its reset value
  localparam int CFG_BITS     = 5;
  localparam int RESET_WINDOW = 5;

  // Control sent from the top level to every cell of the sorted chain
  typedef struct packed {
    logic load;   // shift one sample into the chain
    logic clear;  // drop every sample (window size written)
  } swm_ctl_t;

endpackage

### design/swm_cell.sv
module swm_cell #(
  parameter int IDX         = 0,
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 4,
  parameter int WW          = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  swm_pkg::swm_ctl_t      ctl,
  input  logic [SAMPLE_BITS-1:0] x,
  input  logic [WW-1:0]          newcount,
  input  logic [WW-1:0]          weff_m1,
  input  logic [WW-1:0]          lo_idx,
  input  logic [WW-1:0]          hi_idx,
  input  logic                   del_below_in,
  output logic                   del_below_out,
  input  logic [SAMPLE_BITS-1:0] left_value,
  input  logic [AW-1:0]          left_age,
  input  logic                   left_up,
  input  logic [SAMPLE_BITS-1:0] right_value,
  input  logic [AW-1:0]          right_age,
  input  logic                   right_down,
  output logic [SAMPLE_BITS-1:0] value,
  output logic [AW-1:0]          age,
  output logic                   valid,
  output logic                   up,
  output logic                   down,
  output logic [SAMPLE_BITS-1:0] lo_tap,
  output logic [SAMPLE_BITS-1:0] hi_tap
);

  logic                   del;
  logic                   kept;
  logic                   greater;
  logic                   stay;
  logic                   valid_next;
  logic [SAMPLE_BITS-1:0] value_next;
  logic [AW-1:0]          age_next;

  // The oldest sample of a full window leaves the chain
  assign del           = valid && (WW'(age) == weff_m1);
  assign kept          = valid && !del;
  assign greater       = valid && ($signed(value) > $signed(x));
  assign del_below_out = del_below_in || del;

  // Shift up past the new sample, down into the hole left by the departing one
  assign up   = kept && greater && !del_below_in;
  assign down = kept && !greater && del_below_in;
  assign stay = kept && (greater == del_below_in);

  assign valid_next = WW'(IDX) < newcount;

  always_comb begin
    if (left_up) begin
      value_next = left_value;
      age_next   = AW'(left_age + 1'b1);
    end else if (right_down) begin
      value_next = right_value;
      age_next   = AW'(right_age + 1'b1);
    end else if (stay) begin
      value_next = value;
      age_next   = AW'(age + 1'b1);
    end else begin
      value_next = x;
      age_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= value_next;
      age   <= age_next;
    end
  end

  assign lo_tap = (WW'(IDX) == lo_idx) ? value : '0;
  assign hi_tap = (WW'(IDX) == hi_idx) ? value : '0;

endmodule

### design/sliding_window_median_unit.sv
// Running median filter over the most recent win_len samples.
//
// Input channel: sample with in_valid / in_stall. Output channel:
// median_doubled with out_valid / out_stall. median_doubled is twice the
// median: the middle sample doubled for an odd window, the sum of the two
// middle samples for an even one. No result comes until the window is full.
// Configuration: win_len with cfg_valid / cfg_ready (always ready).
// A value of 0 acts as 1, a value above MAX_WINDOW as MAX_WINDOW. A write
// empties the window; write it only while no item is in flight.
//
// The window lives in a sorted chain of MAX_WINDOW cells. Each accepted item
// drops the oldest sample of a full window and inserts the new one, every
// cell taking from itself or a neighbor. An item that fills the window sets
// pend, and the median moves into the output register once that is free. One
// item per cycle is sustained while the receiver does not stall. When it
// stalls, the result waits in the output register and one more item is taken
// into the chain; after that in_stall rises until the output drains.
// Reset empties the window and sets win_len to 5; stored samples beyond
// the fill count are never used.
module sliding_window_median_unit #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS:0]       median_doubled,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swm_pkg::CFG_BITS-1:0]      win_len
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (WW > swm_pkg::CFG_BITS) ? WW : swm_pkg::CFG_BITS;
  localparam int RESET_W = (swm_pkg::RESET_WINDOW > MAX_WINDOW) ?
                           MAX_WINDOW : swm_pkg::RESET_WINDOW;

  logic [WW-1:0]          weff;
  logic [WW-1:0]          weff_next;
  logic [WW-1:0]          fill_count;
  logic [WW-1:0]          newcount;
  logic                   pend;
  logic                   accept;
  logic                   cfg_write;
  logic                   move;
  logic [CW-1:0]          ws_ext;
  logic [WW-1:0]          weff_m1;
  logic [WW-1:0]          lo_idx;
  logic [WW-1:0]          hi_idx;
  swm_pkg::swm_ctl_t      ctl;

  logic [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
  logic [AW-1:0]          cell_age   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  cell_valid;
  logic [MAX_WINDOW-1:0]  cell_up;
  logic [MAX_WINDOW-1:0]  cell_down;
  logic [MAX_WINDOW:0]    del_chain;
  logic [SAMPLE_BITS-1:0] lo_tap [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] hi_tap [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] lo_value;
  logic [SAMPLE_BITS-1:0] hi_value;
  logic [SAMPLE_BITS:0]   sum;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign move     = pend && (!out_valid || !out_stall);
  assign in_stall = pend && !move;
  assign accept   = in_valid && !in_stall;

  assign newcount = (fill_count == weff) ? weff : WW'(fill_count + 1'b1);
  assign weff_m1  = WW'(weff - 1'b1);
  assign lo_idx   = weff_m1 >> 1;
  assign hi_idx   = weff >> 1;

  assign ctl.load  = accept;
  assign ctl.clear = cfg_write;

  always_comb begin
    ws_ext = CW'(win_len);
    if (ws_ext == '0) begin
      weff_next = WW'(1);
    end else if (ws_ext > CW'(MAX_WINDOW)) begin
      weff_next = WW'(MAX_WINDOW);
    end else begin
      weff_next = WW'(ws_ext);
    end
  end

  assign del_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lv;
    logic [AW-1:0]          la;
    logic                   lu;
    logic [SAMPLE_BITS-1:0] rv;
    logic [AW-1:0]          ra;
    logic                   rd;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign la = '0;
      assign lu = 1'b0;
    end else begin : g_left
      assign lv = cell_value[i-1];
      assign la = cell_age[i-1];
      assign lu = cell_up[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign rv = '0;
      assign ra = '0;
      assign rd = 1'b0;
    end else begin : g_right
      assign rv = cell_value[i+1];
      assign ra = cell_age[i+1];
      assign rd = cell_down[i+1];
    end

    swm_cell #(
      .IDX         (i),
      .SAMPLE_BITS (SAMPLE_BITS),
      .AW          (AW),
      .WW          (WW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .x             (sample),
      .newcount      (newcount),
      .weff_m1       (weff_m1),
      .lo_idx        (lo_idx),
      .hi_idx        (hi_idx),
      .del_below_in  (del_chain[i]),
      .del_below_out (del_chain[i+1]),
      .left_value    (lv),
      .left_age      (la),
      .left_up       (lu),
      .right_value   (rv),
      .right_age     (ra),
      .right_down    (rd),
      .value         (cell_value[i]),
      .age           (cell_age[i]),
      .valid         (cell_valid[i]),
      .up            (cell_up[i]),
      .down          (cell_down[i]),
      .lo_tap        (lo_tap[i]),
      .hi_tap        (hi_tap[i])
    );
  end

  // Exactly one cell drives each tap; the rest give zero
  always_comb begin
    lo_value = '0;
    hi_value = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      lo_value = lo_value | lo_tap[i];
      hi_value = hi_value | hi_tap[i];
    end
  end

  assign sum = {lo_value[SAMPLE_BITS-1], lo_value} + {hi_value[SAMPLE_BITS-1], hi_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      weff       <= WW'(RESET_W);
      fill_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        weff       <= weff_next;
        fill_count <= '0;
        pend       <= 1'b0;
      end else if (accept) begin
        fill_count <= newcount;
        pend       <= (newcount == weff);
      end else if (move) begin
        pend <= 1'b0;
      end

      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      median_doubled <= sum;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= weff)
    else $error("fill count beyond window size");

  a_cells_match_fill: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(fill_count))
    else $error("occupied cells disagree with fill count");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("occupied cells not packed at the bottom of the chain");

  a_full_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_write && newcount == weff) |=> pend)
    else $error("full window produced no result");

  a_one_drop: assert property (@(posedge clk) disable iff (rst)
    accept |-> (del_chain[MAX_WINDOW] == (fill_count == weff)))
    else $error("departing sample count wrong");

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX       = 16;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 1750;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [15:0]       sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [16:0]       median_doubled;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [swm_pkg::CFG_BITS-1:0] win_len = swm_pkg::CFG_BITS'(swm_pkg::RESET_WINDOW);

  // predictor state
  logic signed [15:0] ring [WIN_MAX];
  int                 ring_wr = 0;
  int                 fill_level = 0;
  logic [swm_pkg::CFG_BITS-1:0] window_cfg = swm_pkg::CFG_BITS'(swm_pkg::RESET_WINDOW);

  logic signed [15:0] sample_q [$];
  logic signed [16:0] median_q [$];
  logic signed [16:0] want;
  logic signed [16:0] twice_pred;
  logic signed [15:0] last_pick = '0;

  int  sender_idle_pct = 16;
  int  receiver_stall_pct = 53;
  bit  in_taken = 1'b0;
  bit  error_seen = 1'b0;
  int  idle_cycles = 0;

  sliding_window_median_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .median_doubled (median_doubled),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .win_len        (win_len)
  );

  always #4 clk = ~clk;

  // Push one sample through the window; return 1 with twice the median once full.
  function automatic bit slide_median(input logic signed [15:0] s,
                                      output logic signed [16:0] twice);
    logic signed [15:0] win [WIN_MAX];
    logic signed [15:0] v;
    logic signed [16:0] lo, hi;
    int w, k, j;
    w = window_cfg;
    if (w == 0) w = 1;
    if (w > WIN_MAX) w = WIN_MAX;
    ring[ring_wr] = s;
    ring_wr = (ring_wr + 1) % WIN_MAX;
    if (fill_level < w) fill_level++;
    twice = '0;
    if (fill_level < w) return 1'b0;
    for (k = 0; k < w; k++) begin
      v = ring[(ring_wr + WIN_MAX - 1 - k) % WIN_MAX];
      j = k;
      while (j > 0 && win[j-1] > v) begin
        win[j] = win[j-1];
        j--;
      end
      win[j] = v;
    end
    hi = win[w/2];
    lo = (w % 2 == 1) ? win[w/2] : win[w/2 - 1];
    twice = lo + hi;
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0, 1: last_pick = 16'($urandom);
      2: last_pick = 16'($signed($urandom_range(0, 8)) - 4);
      3: begin
        case ($urandom_range(0, 3))
          0: last_pick = 16'sh7fff;
          1: last_pick = 16'sh8000;
          2: last_pick = 16'sh0000;
          default: last_pick = 16'shffff;
        endcase
      end
      4: last_pick = last_pick;
      default: last_pick = last_pick + 16'($signed($urandom_range(0, 6)) - 3);
    endcase
    return last_pick;
  endfunction

  // Sender: hold a stalled item, otherwise present the next one or idle.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        sample   <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // Predict on accepted items, check accepted results, watch for a hang.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      idle_cycles++;
      if (cfg_valid && cfg_ready) begin
        window_cfg = win_len;
        fill_level = 0;
        idle_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        idle_cycles = 0;
        if (slide_median(sample, twice_pred)) median_q.push_back(twice_pred);
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (median_q.size() == 0) begin
          $display("%0t: median_doubled expected none, got %0d", $time, median_doubled);
          error_seen = 1'b1;
        end else begin
          want = median_q.pop_front();
          if (median_doubled !== want) begin
            $display("%0t: median_doubled expected %0d, got %0d", $time, want,
                     median_doubled);
            error_seen = 1'b1;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("sliding_window_median_unit verification failed");
        $finish;
      end
    end
  end

  // Wait until every item is taken and every result is out, then let the chain settle.
  task automatic drain();
    while (sample_q.size() != 0 || in_valid || median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input int w);
    @(negedge clk);
    cfg_valid <= 1'b1;
    win_len   <= swm_pkg::CFG_BITS'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int settings [10];
    int random_total;
    int phase_idx;
    int w;
    int n;
    int k;
    settings = '{1, 16, 2, 0, 31, 17, 3, 15, 8, 4};
    random_total = 0;
    phase_idx = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset window of five: extremes and sign boundaries
    sample_q.push_back(16'sh7fff);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(16'shffff);
    sample_q.push_back(16'sh0000);
    sample_q.push_back(16'sh0001);
    sample_q.push_back(16'sh7fff);
    sample_q.push_back(16'sh8000);
    // zero acts as a window of one
    drain();
    write_window(0);
    sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh7fff);
    // oversize acts as the full window; even window sums the two middles
    drain();
    write_window(31);
    for (k = 0; k < WIN_MAX; k++) begin
      if (k < 6) sample_q.push_back(16'sh7fff);
      else if (k < 12) sample_q.push_back(16'sh8000);
      else sample_q.push_back(k[0] ? 16'sh0001 : 16'shffff);
    end

    while (random_total < RANDOM_ITEMS) begin
      w = (phase_idx < 10) ? settings[phase_idx] : $urandom_range(0, 31);
      n = $urandom_range(20, 120);
      drain();
      if (random_total < RANDOM_ITEMS / 3) begin
        sender_idle_pct = 16;
        receiver_stall_pct = 53;
      end else if (random_total < 2 * RANDOM_ITEMS / 3) begin
        sender_idle_pct = 53;
        receiver_stall_pct = 16;
      end else begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      write_window(w);
      repeat (n) sample_q.push_back(pick_sample());
      random_total += n;
      phase_idx++;
    end
    drain();

    if (median_q.size() != 0) begin
      $display("%0t: median_doubled expected %0d, got none (%0d left)", $time,
               median_q[0], median_q.size());
      error_seen = 1'b1;
    end
    if (!error_seen) begin
      $display("sliding_window_median_unit verification clean");
    end else begin
      $display("sliding_window_median_unit verification failed");
    end
    $finish;
  end

endmodule
